### hw/rtl/aat_pkg.sv
// shared types, constants and the arctangent table for the annular arc point test
// used by aat_cordic, annular_arc_point_test, aat_checker and the testbench; no dependencies

package aat_pkg;

   localparam int COORD_W         = 20;
   localparam int DIFF_W          = COORD_W + 1;
   localparam int RAD_W           = 19;
   localparam int RSUM_W          = RAD_W + 1;
   localparam int SQ_W            = 2 * DIFF_W - 1;
   localparam int D2_W            = SQ_W + 1;
   localparam int RSQ_W           = 2 * RSUM_W;
   localparam int ANGLE_W         = 32;
   localparam int ANGLE_FRAC_BITS = 16;
   localparam int CORDIC_STEPS    = 16;
   localparam int ATAN_LEN        = 24;
   localparam int PRESCALE        = 16;
   localparam int CORDIC_W        = DIFF_W + PRESCALE + 3;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 32;
   localparam int REQ_DATA_W      = 2 * COORD_W;
   localparam int RSP_DATA_W      = 8;

   localparam logic signed [ANGLE_W-1:0] ONE_TURN  = 32'sh1 <<< ANGLE_FRAC_BITS;
   localparam logic        [ANGLE_W-1:0] HALF_TURN = 32'h8000_0000;
   localparam logic        [ANGLE_W-1:0] ROUND_BIT = 32'h1 << (31 - ANGLE_FRAC_BITS);

   // atan(2^-i) in 2^-32 turn units, rounded to nearest
   localparam logic [ANGLE_W-1:0] ATAN_TURNS [ATAN_LEN] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CENTER_X        = 3'd0,
      CSR_CENTER_Y        = 3'd1,
      CSR_ARC_RADIUS      = 3'd2,
      CSR_BAND_HALF_WIDTH = 3'd3,
      CSR_START_ANGLE     = 3'd4,
      CSR_SWEEP_ANGLE     = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic signed [CORDIC_W-1:0] x;
      logic signed [CORDIC_W-1:0] y;
      logic        [ANGLE_W-1:0]  z;
   } cordic_vec_type;

   // per-item decisions that ride beside the rotation
   typedef struct packed {
      logic                       radial_ok;
      logic                       full;
      logic                       neg;
      logic                       zero;
      logic [ANGLE_FRAC_BITS-1:0] s;
      logic [ANGLE_FRAC_BITS-1:0] e;
   } side_type;

endpackage

### hw/rtl/aat_cordic.sv
// vectoring cordic pipeline, one micro-rotation per register stage
// depends on aat_pkg (vector and sideband types, arctangent table)

module aat_cordic (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    en,
   input  logic                    in_valid,
   input  aat_pkg::cordic_vec_type in_vec,
   input  aat_pkg::side_type       in_side,
   output logic                    out_valid,
   output aat_pkg::cordic_vec_type out_vec,
   output aat_pkg::side_type       out_side
);

   localparam int N = aat_pkg::CORDIC_STEPS;

   logic [N-1:0]            valid_ff;
   aat_pkg::cordic_vec_type vec_ff  [N];
   aat_pkg::side_type       side_ff [N];

   genvar i;
   generate
      for (i = 0; i < N; i++) begin : g_stage
         logic signed [aat_pkg::CORDIC_W-1:0] x_cur, y_cur, xs, ys;
         logic        [aat_pkg::ANGLE_W-1:0]  z_cur;
         logic                                v_cur;
         aat_pkg::side_type                   side_cur;
         aat_pkg::cordic_vec_type             vec_in;

         if (i == 0) begin : g_first
            assign x_cur    = in_vec.x;
            assign y_cur    = in_vec.y;
            assign z_cur    = in_vec.z;
            assign v_cur    = in_valid;
            assign side_cur = in_side;
         end else begin : g_next
            assign x_cur    = vec_ff[i-1].x;
            assign y_cur    = vec_ff[i-1].y;
            assign z_cur    = vec_ff[i-1].z;
            assign v_cur    = valid_ff[i-1];
            assign side_cur = side_ff[i-1];
         end

         assign xs = x_cur >>> i;
         assign ys = y_cur >>> i;

         // rotate toward the x axis, sign of y picks the direction
         always_comb begin
            if (!y_cur[aat_pkg::CORDIC_W-1]) begin
               vec_in.x = x_cur + ys;
               vec_in.y = y_cur - xs;
               vec_in.z = z_cur + aat_pkg::ATAN_TURNS[i];
            end else begin
               vec_in.x = x_cur - ys;
               vec_in.y = y_cur + xs;
               vec_in.z = z_cur - aat_pkg::ATAN_TURNS[i];
            end
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[i] <= 1'b0;
            end else if (en) begin
               valid_ff[i] <= v_cur;
            end
         end

         always_ff @(posedge clock) begin
            if (en) begin
               vec_ff[i]  <= vec_in;
               side_ff[i] <= side_cur;
            end
         end
      end
   endgenerate

   assign out_valid = valid_ff[N-1];
   assign out_vec   = vec_ff[N-1];
   assign out_side  = side_ff[N-1];

endmodule

### hw/rtl/annular_arc_point_test.sv
// a req transfer passes 4 setup stages, one stage per cordic iteration and one result
//   stage before rsp_tvalid; one point per cycle while the skid entry is empty
// the cordic pipeline is the deepest part; an output register plus a skid entry keep
//   req_tready registered and let two results wait on a stalled rsp side
// reset (synchronous): all valid bits clear, registers take their reset values
// depends on aat_pkg and aat_cordic

module annular_arc_point_test (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [aat_pkg::REQ_DATA_W-1:0]     req_tdata,  // point_x, point_y
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [aat_pkg::RSP_DATA_W-1:0]     rsp_tdata,  // inside_res, zero fill
   input  logic                               csr_wr_en,
   input  logic [aat_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [aat_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   localparam int F = aat_pkg::ANGLE_FRAC_BITS;

   // configuration registers
   logic signed [aat_pkg::COORD_W-1:0] center_x_ff, center_y_ff;
   logic        [aat_pkg::RAD_W-1:0]   arc_radius_ff, band_half_width_ff;
   logic        [aat_pkg::ANGLE_W-1:0] start_angle_ff;
   logic signed [aat_pkg::ANGLE_W-1:0] sweep_angle_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_x_ff        <= '0;
         center_y_ff        <= '0;
         arc_radius_ff      <= aat_pkg::RAD_W'(16);
         band_half_width_ff <= '0;
         start_angle_ff     <= '0;
         sweep_angle_ff     <= aat_pkg::ONE_TURN;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            aat_pkg::CSR_CENTER_X:        center_x_ff        <= csr_wdata[aat_pkg::COORD_W-1:0];
            aat_pkg::CSR_CENTER_Y:        center_y_ff        <= csr_wdata[aat_pkg::COORD_W-1:0];
            aat_pkg::CSR_ARC_RADIUS:      arc_radius_ff      <= csr_wdata[aat_pkg::RAD_W-1:0];
            aat_pkg::CSR_BAND_HALF_WIDTH: band_half_width_ff <= csr_wdata[aat_pkg::RAD_W-1:0];
            aat_pkg::CSR_START_ANGLE:     start_angle_ff     <= csr_wdata[aat_pkg::ANGLE_W-1:0];
            aat_pkg::CSR_SWEEP_ANGLE:     sweep_angle_ff     <= csr_wdata[aat_pkg::ANGLE_W-1:0];
            default: ;
         endcase
      end
   end

   // whole pipeline moves unless the skid entry is occupied
   logic en;
   logic skid_valid_ff;
   assign en         = !skid_valid_ff;
   assign req_tready = en;

   logic signed [aat_pkg::COORD_W-1:0] point_x, point_y;
   assign point_x = req_tdata[aat_pkg::COORD_W-1:0];
   assign point_y = req_tdata[aat_pkg::REQ_DATA_W-1:aat_pkg::COORD_W];

   // stage 1: differences, radii, angle window
   logic                               v1_ff;
   logic signed [aat_pkg::DIFF_W-1:0]  dx1_ff, dy1_ff;
   logic        [aat_pkg::RSUM_W-1:0]  rmax1_ff;
   logic signed [aat_pkg::RSUM_W-1:0]  rmin1_ff;
   logic                               full1_ff, neg1_ff;
   logic        [F-1:0]                s1_ff, e1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dx1_ff   <= aat_pkg::DIFF_W'(point_x) - aat_pkg::DIFF_W'(center_x_ff);
         dy1_ff   <= aat_pkg::DIFF_W'(point_y) - aat_pkg::DIFF_W'(center_y_ff);
         rmax1_ff <= aat_pkg::RSUM_W'(arc_radius_ff) + aat_pkg::RSUM_W'(band_half_width_ff);
         rmin1_ff <= signed'(aat_pkg::RSUM_W'(arc_radius_ff))
                     - signed'(aat_pkg::RSUM_W'(band_half_width_ff));
         full1_ff <= (sweep_angle_ff >= aat_pkg::ONE_TURN)
                     || (sweep_angle_ff <= -aat_pkg::ONE_TURN);
         neg1_ff  <= sweep_angle_ff[aat_pkg::ANGLE_W-1];
         s1_ff    <= start_angle_ff[F-1:0];
         e1_ff    <= start_angle_ff[F-1:0] + sweep_angle_ff[F-1:0];
      end
   end

   // stage 2: squares
   logic [aat_pkg::DIFF_W-1:0] adx, ady;
   logic [2*aat_pkg::DIFF_W-1:0] dxx_full, dyy_full;
   logic [aat_pkg::RSQ_W-1:0]  rmax_sq_full, rmin_sq_full;

   assign adx          = dx1_ff[aat_pkg::DIFF_W-1] ? aat_pkg::DIFF_W'(-dx1_ff) : dx1_ff;
   assign ady          = dy1_ff[aat_pkg::DIFF_W-1] ? aat_pkg::DIFF_W'(-dy1_ff) : dy1_ff;
   assign dxx_full     = adx * adx;
   assign dyy_full     = ady * ady;
   assign rmax_sq_full = rmax1_ff * rmax1_ff;
   assign rmin_sq_full = aat_pkg::RSUM_W'(rmin1_ff) * aat_pkg::RSUM_W'(rmin1_ff);

   logic                               v2_ff;
   logic [aat_pkg::SQ_W-1:0]           dxx2_ff, dyy2_ff;
   logic [aat_pkg::RSQ_W-1:0]          rmax_sq2_ff, rmin_sq2_ff;
   logic                               inner2_ff;
   logic signed [aat_pkg::DIFF_W-1:0]  dx2_ff, dy2_ff;
   logic                               full2_ff, neg2_ff;
   logic [F-1:0]                       s2_ff, e2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (en) begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dxx2_ff     <= dxx_full[aat_pkg::SQ_W-1:0];
         dyy2_ff     <= dyy_full[aat_pkg::SQ_W-1:0];
         rmax_sq2_ff <= rmax_sq_full;
         rmin_sq2_ff <= rmin_sq_full;
         // inner bound only counts for a positive inner radius
         inner2_ff   <= (rmin1_ff > 0);
         dx2_ff      <= dx1_ff;
         dy2_ff      <= dy1_ff;
         full2_ff    <= full1_ff;
         neg2_ff     <= neg1_ff;
         s2_ff       <= s1_ff;
         e2_ff       <= e1_ff;
      end
   end

   // stage 3: squared distance
   logic                               v3_ff;
   logic [aat_pkg::D2_W-1:0]           d2_3_ff;
   logic [aat_pkg::RSQ_W-1:0]          rmax_sq3_ff, rmin_sq3_ff;
   logic                               inner3_ff;
   logic signed [aat_pkg::DIFF_W-1:0]  dx3_ff, dy3_ff;
   logic                               full3_ff, neg3_ff;
   logic [F-1:0]                       s3_ff, e3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (en) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         d2_3_ff     <= aat_pkg::D2_W'(dxx2_ff) + aat_pkg::D2_W'(dyy2_ff);
         rmax_sq3_ff <= rmax_sq2_ff;
         rmin_sq3_ff <= rmin_sq2_ff;
         inner3_ff   <= inner2_ff;
         dx3_ff      <= dx2_ff;
         dy3_ff      <= dy2_ff;
         full3_ff    <= full2_ff;
         neg3_ff     <= neg2_ff;
         s3_ff       <= s2_ff;
         e3_ff       <= e2_ff;
      end
   end

   // stage 4: radial decision and cordic start vector
   logic signed [aat_pkg::CORDIC_W-1:0] x0, y0;
   aat_pkg::cordic_vec_type             vec4_in;
   aat_pkg::side_type                   side4_in;

   assign x0 = aat_pkg::CORDIC_W'(dx3_ff) <<< aat_pkg::PRESCALE;
   assign y0 = aat_pkg::CORDIC_W'(dy3_ff) <<< aat_pkg::PRESCALE;

   always_comb begin
      // left half plane: turn by half a turn first
      if (x0[aat_pkg::CORDIC_W-1]) begin
         vec4_in.x = -x0;
         vec4_in.y = -y0;
         vec4_in.z = aat_pkg::HALF_TURN;
      end else begin
         vec4_in.x = x0;
         vec4_in.y = y0;
         vec4_in.z = '0;
      end
      side4_in.radial_ok = !(d2_3_ff > aat_pkg::D2_W'(rmax_sq3_ff))
                           && !(inner3_ff && (d2_3_ff < aat_pkg::D2_W'(rmin_sq3_ff)));
      side4_in.full      = full3_ff;
      side4_in.neg       = neg3_ff;
      side4_in.zero      = (dx3_ff == '0) && (dy3_ff == '0);
      side4_in.s         = s3_ff;
      side4_in.e         = e3_ff;
   end

   logic                    v4_ff;
   aat_pkg::cordic_vec_type vec4_ff;
   aat_pkg::side_type       side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (en) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         vec4_ff  <= vec4_in;
         side4_ff <= side4_in;
      end
   end

   // cordic pipeline
   logic                    cv;
   aat_pkg::cordic_vec_type cvec;
   aat_pkg::side_type       cside;

   aat_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (v4_ff),
      .in_vec    (vec4_ff),
      .in_side   (side4_ff),
      .out_valid (cv),
      .out_vec   (cvec),
      .out_side  (cside)
   );

   // result: round the angle, test it against the span and combine with the radial decision
   logic [aat_pkg::ANGLE_W-1:0] z_rnd;
   logic [F-1:0]                ang;
   logic                        ang_ok;
   logic                        inside_c;

   assign z_rnd = cvec.z + aat_pkg::ROUND_BIT;
   assign ang   = cside.zero ? '0 : z_rnd[aat_pkg::ANGLE_W-1 -: F];

   always_comb begin
      if (!cside.neg) begin
         if (cside.s <= cside.e) ang_ok = (ang >= cside.s) && (ang <= cside.e);
         else                    ang_ok = (ang >= cside.s) || (ang <= cside.e);
      end else begin
         if (cside.e <= cside.s) ang_ok = (ang >= cside.e) && (ang <= cside.s);
         else                    ang_ok = (ang >= cside.e) || (ang <= cside.s);
      end
      inside_c = cside.radial_ok && (cside.full || ang_ok);
   end

   // output register with one skid entry
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_inside_ff, rsp_inside_in;
   logic skid_valid_in;
   logic skid_inside_ff, skid_inside_in;
   logic take;

   assign take = rsp_valid_ff && rsp_tready;

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_inside_in  = rsp_inside_ff;
      skid_valid_in  = skid_valid_ff;
      skid_inside_in = skid_inside_ff;
      if (skid_valid_ff) begin
         if (take) begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = skid_inside_ff;
            skid_valid_in = 1'b0;
         end
      end else if (cv) begin
         if (!rsp_valid_ff || take) begin
            rsp_valid_in  = 1'b1;
            rsp_inside_in = inside_c;
         end else begin
            skid_valid_in  = 1'b1;
            skid_inside_in = inside_c;
         end
      end else if (take) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_inside_ff  <= rsp_inside_in;
      skid_inside_ff <= skid_inside_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = aat_pkg::RSP_DATA_W'(rsp_inside_ff);

endmodule

### hw/rtl/aat_checker.sv
// port-level checks for annular_arc_point_test, attached by bind
// depends on aat_pkg for port widths

module aat_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tready,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [aat_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp transfer changed while stalled");

   // input backpressure only when results are waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("req_tready low with no result pending");

   // one rsp transfer frees the skid entry
   a_stall_release: assert property (@(posedge clock) disable iff (reset)
      !req_tready && rsp_tready |=> req_tready)
      else $error("req_tready stayed low after rsp transfer");

   // nothing comes out right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid && req_tready)
      else $error("output active right after reset");

endmodule

bind annular_arc_point_test aat_checker u_aat_checker (.*);

### tb/tb.sv
// self-checking testbench for annular_arc_point_test: streams points through the req side,
// predicts the in-region flag per point and compares it with every rsp transfer
// depends on aat_pkg and the annular_arc_point_test rtl

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int IDLE_PCT       = 36;
   localparam int FLUSH_CYCLES   = 40;
   localparam int ARC_STEPS      = 16;
   localparam int TURN_FRAC      = 16;
   localparam int RANDOM_PHASES  = 8;
   localparam int PHASE_POINTS   = 116;

   // atan(2^-i) in 2^-32 turn units
   localparam logic [31:0] ATAN_STEP_TURNS [ARC_STEPS] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861
   };

   typedef struct packed {
      logic [aat_pkg::REQ_DATA_W-1:0] point;
      logic                           hit;
   } arc_verdict_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [aat_pkg::REQ_DATA_W-1:0]  req_tdata = '0;   // point_x, point_y
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [aat_pkg::RSP_DATA_W-1:0]  rsp_tdata;        // inside_res, zero fill
   logic                            csr_wr_en = 1'b0;
   logic [aat_pkg::CSR_INDEX_W-1:0] csr_index = aat_pkg::CSR_CENTER_X;
   logic [aat_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // region registers as the block should hold them
   logic signed [19:0] region_cx     = '0;
   logic signed [19:0] region_cy     = '0;
   logic        [18:0] region_rad    = 19'd16;
   logic        [18:0] region_band   = '0;
   logic signed [31:0] region_start  = '0;
   logic signed [31:0] region_sweep  = 32'sd65536;

   logic [aat_pkg::REQ_DATA_W-1:0] point_queue [$];
   arc_verdict_type                verdict_due [$];
   arc_verdict_type                verdict_now;
   logic                  req_fired = 1'b0;
   int                    idle_pct = IDLE_PCT;
   int                    points_queued = 0;
   int                    points_sent = 0;
   int                    results_seen = 0;
   int                    hit_count = 0;
   int                    region_count = 0;
   int                    mismatch_count = 0;
   int                    stall_cycles = 0;

   annular_arc_point_test i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // vectoring rotation: direction of (dx, dy) in turns, 16 fraction bits
   function automatic logic [TURN_FRAC-1:0] point_turns(longint dx, longint dy);
      longint      x, y, xs, ys;
      logic [31:0] z;
      int          i;
      if (dx == 0 && dy == 0)
         return '0;
      x = dx * 65536;
      y = dy * 65536;
      z = '0;
      if (x < 0) begin
         x = -x;
         y = -y;
         z = 32'h8000_0000;
      end
      for (i = 0; i < ARC_STEPS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y >= 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_STEP_TURNS[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_STEP_TURNS[i];
         end
      end
      z = z + (32'h1 << (31 - TURN_FRAC));
      return z[31:32-TURN_FRAC];
   endfunction

   function automatic logic arc_point_hit(logic [aat_pkg::REQ_DATA_W-1:0] point);
      logic signed [19:0]     px, py;
      longint                 dx, dy, d2, rmin, rmax, mag;
      logic [31:0]            end_turn;
      logic [TURN_FRAC-1:0]   s, e, a;
      px = point[19:0];
      py = point[39:20];
      dx = longint'(px) - longint'(region_cx);
      dy = longint'(py) - longint'(region_cy);
      d2 = dx * dx + dy * dy;
      rmin = longint'(region_rad) - longint'(region_band);
      rmax = longint'(region_rad) + longint'(region_band);
      mag = region_sweep < 0 ? -longint'(region_sweep) : longint'(region_sweep);
      if (d2 > rmax * rmax || (rmin > 0 && d2 < rmin * rmin))
         return 1'b0;
      if (mag >= (longint'(1) << TURN_FRAC))
         return 1'b1;
      end_turn = region_start + region_sweep;
      s = region_start[TURN_FRAC-1:0];
      e = end_turn[TURN_FRAC-1:0];
      a = point_turns(dx, dy);
      if (region_sweep >= 0)
         return (s <= e) ? (a >= s && a <= e) : (a >= s || a <= e);
      return (e <= s) ? (a >= e && a <= s) : (a >= e || a <= s);
   endfunction

   task automatic report_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatch_count++;
   endtask

   // driver: points from the queue, random gaps on both sides
   always @(negedge clock) begin
      if (reset)
         req_tvalid <= 1'b0;
      else if (!req_tvalid || req_fired) begin
         if (point_queue.size() != 0 && $urandom_range(99) >= idle_pct) begin
            req_tvalid <= 1'b1;
            req_tdata  <= point_queue.pop_front();
         end else
            req_tvalid <= 1'b0;
      end
      rsp_tready <= $urandom_range(99) >= idle_pct;
   end

   // monitor: predict on each req transfer, check on each rsp transfer
   always @(posedge clock) begin
      req_fired <= !reset && req_tvalid && req_tready;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            verdict_due.insert(verdict_due.size(),
                               '{point: req_tdata, hit: arc_point_hit(req_tdata)});
            points_sent++;
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (verdict_due.size() == 0)
               report_mismatch($sformatf("result %0d arrived with no point pending",
                                         results_seen));
            else begin
               verdict_now = verdict_due.pop_front();
               if (verdict_now.hit)
                  hit_count++;
               if (rsp_tdata[0] !== verdict_now.hit)
                  report_mismatch($sformatf("point x=%0d y=%0d: inside_res %b, want %b",
                                            $signed(verdict_now.point[19:0]),
                                            $signed(verdict_now.point[39:20]),
                                            rsp_tdata[0], verdict_now.hit));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_wr_en)
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
         $display("Mismatches found");
         $finish;
      end
   end

   task automatic csr_put(aat_pkg::csr_index_type idx, logic [31:0] value);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
   endtask

   // only called with nothing in flight
   task automatic set_region(logic [19:0] cx, logic [19:0] cy, logic [18:0] rad,
                             logic [18:0] band, logic [31:0] start, logic [31:0] sweep);
      region_cx    = cx;
      region_cy    = cy;
      region_rad   = rad;
      region_band  = band;
      region_start = start;
      region_sweep = sweep;
      region_count++;
      csr_put(aat_pkg::CSR_CENTER_X, {12'd0, cx});
      csr_put(aat_pkg::CSR_CENTER_Y, {12'd0, cy});
      csr_put(aat_pkg::CSR_ARC_RADIUS, {13'd0, rad});
      csr_put(aat_pkg::CSR_BAND_HALF_WIDTH, {13'd0, band});
      csr_put(aat_pkg::CSR_START_ANGLE, start);
      csr_put(aat_pkg::CSR_SWEEP_ANGLE, sweep);
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic queue_point(int x, int y);
      point_queue.insert(point_queue.size(), {y[19:0], x[19:0]});
      points_queued++;
   endtask

   task automatic drain_results();
      do
         @(negedge clock);
      while (points_sent != points_queued || verdict_due.size() != 0);
   endtask

   task automatic pick_random_region();
      logic [18:0] rad, band;
      logic [31:0] sweep;
      int          span;
      case ($urandom_range(3))
         0: rad = 19'($urandom_range(1, 64));
         1: rad = 19'($urandom_range(1, 5000));
         2: rad = 19'($urandom);
         default: rad = '1;
      endcase
      if (rad == 0)
         rad = 1;
      case ($urandom_range(3))
         0: band = '0;
         1: band = 19'($urandom_range(0, rad));
         2: band = 19'($urandom_range(0, 64));
         default: band = 19'($urandom);
      endcase
      case ($urandom_range(7))
         0: sweep = '0;
         1: sweep = $urandom;
         2: sweep = $urandom_range(1) ? 32'sd65536 : -32'sd65536;
         default: begin
            span = $urandom_range(1, 65535);
            sweep = $urandom_range(1) ? span : -span;
         end
      endcase
      set_region(20'($urandom), 20'($urandom), rad, band, $urandom, sweep);
   endtask

   // mostly points on or near the ring, some anywhere, some on the radial limits
   task automatic queue_random_point();
      int     cxi, cyi, ox, oy, r, lim;
      int     rmin, rmax;
      cxi  = region_cx;
      cyi  = region_cy;
      rmin = int'(region_rad) - int'(region_band);
      rmax = int'(region_rad) + int'(region_band);
      case ($urandom_range(9))
         0: begin
            cxi = 0;
            cyi = 0;
            ox  = $urandom;
            oy  = $urandom;
         end
         1, 2: begin
            lim = rmax + 2;
            ox  = int'($urandom_range(0, 2 * lim)) - lim;
            oy  = int'($urandom_range(0, 2 * lim)) - lim;
         end
         8, 9: begin
            case ($urandom_range(3))
               0: r = rmin - 1;
               1: r = rmin;
               2: r = rmax;
               default: r = rmax + 1;
            endcase
            if (r < 0)
               r = rmax;
            case ($urandom_range(3))
               0: begin ox = r;  oy = 0;  end
               1: begin ox = -r; oy = 0;  end
               2: begin ox = 0;  oy = r;  end
               default: begin ox = 0; oy = -r; end
            endcase
         end
         default: begin
            lim = rmin > 0 ? rmin : 0;
            r   = lim + int'($urandom_range(0, rmax - lim));
            ox  = int'($urandom_range(0, 2 * r)) - r;
            oy  = int'($sqrt(real'(longint'(r) * r - longint'(ox) * ox)));
            if ($urandom_range(1))
               oy = -oy;
         end
      endcase
      queue_point(cxi + ox, cyi + oy);
   endtask

   initial begin
      int phase, k;
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      // reset region: ring of radius 16 with zero band, full turn
      queue_point(16, 0);
      queue_point(0, -16);
      queue_point(-16, 0);
      queue_point(0, 0);
      queue_point(17, 0);
      queue_point(-524288, -524288);
      queue_point(524287, 524287);
      drain_results();

      // inner radius zero, quarter turn from zero, point at the centre
      set_region(20'd0, 20'd0, 19'd100, 19'd100, 32'd0, 32'd16384);
      queue_point(0, 0);
      queue_point(150, 0);
      queue_point(0, 150);
      queue_point(-150, 0);
      queue_point(200, 0);
      queue_point(201, 0);
      drain_results();

      // extreme centre and radii, negative sweep from a wrapped start
      set_region(20'h80000, 20'h7FFFF, 19'h7FFFF, 19'h7FFFF, 32'hFFFF_C000, -32'sd16384);
      queue_point(524287, -524288);
      queue_point(-524288, 0);
      queue_point(0, 524287);
      drain_results();

      // positive sweep across the zero angle, ring boundaries
      set_region(20'd100, -20'sd100, 19'd50, 19'd10, 32'h0000_F000, 32'h0000_2000);
      queue_point(160, -100);
      queue_point(100, -40);
      queue_point(140, -100);
      queue_point(139, -100);
      drain_results();

      // negative sweep across the zero angle
      set_region(20'd100, -20'sd100, 19'd50, 19'd10, 32'h0000_1000, -32'sd8192);
      queue_point(160, -100);
      queue_point(100, -40);
      drain_results();

      // most negative sweep counts as a full turn
      set_region(20'd100, -20'sd100, 19'd50, 19'd10, 32'h7FFF_FFFF, 32'h8000_0000);
      queue_point(100, -160);
      queue_point(100, -40);
      drain_results();

      // zero sweep: only the start direction passes
      set_region(20'd100, -20'sd100, 19'd50, 19'd10, 32'h0001_0000, 32'd0);
      queue_point(160, -100);
      queue_point(100, -40);
      drain_results();

      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         pick_random_region();
         idle_pct = (phase == 2) ? 0 : IDLE_PCT;
         for (k = 0; k < PHASE_POINTS / 2; k++)
            queue_random_point();
         // hold the sender until the pipe is empty
         drain_results();
         for (k = 0; k < PHASE_POINTS - PHASE_POINTS / 2; k++)
            queue_random_point();
         drain_results();
      end

      repeat (FLUSH_CYCLES) @(negedge clock);
      $display("checked %0d points against %0d region settings", results_seen, region_count + 1);
      $display("%0d points fell in the region, %0d did not", hit_count,
               results_seen - hit_count);
      if (mismatch_count == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

### files.f
hw/rtl/aat_pkg.sv
hw/rtl/aat_cordic.sv
hw/rtl/annular_arc_point_test.sv
hw/rtl/aat_checker.sv
tb/tb.sv
